FILE: hdl/fwr_pkg.sv
// shared constants and types for the full-weighting restriction block
`default_nettype none
package fwr_pkg;

  localparam int MAX_LEVEL  = 10;
  localparam int MIN_LEVEL  = 2;
  localparam int SAMPLE_W   = 32;
  localparam int LEVEL_W    = 4;
  localparam int LINE_DEPTH = (2 ** MAX_LEVEL) + 1;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = MAX_LEVEL + 1;
  localparam int COORD_W    = MAX_LEVEL - 1;
  localparam int SUM_W      = SAMPLE_W + 4;
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 2 * COORD_W + SAMPLE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(MAX_LEVEL);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic               hit;
    logic               last;
    logic [COORD_W-1:0] coarse_row;
    logic [COORD_W-1:0] coarse_col;
    logic [ADDR_W-1:0]  addr;
  } fwr_ctrl_t;

endpackage
`default_nettype wire

FILE: hdl/full_weighting_restriction_top.sv
// top level of the streaming full-weighting restriction block
// an accepted input beat is held in the s1 register, then its result in the output register
// throughput: 1 fine sample per cycle unless stalled; results only at coarse inner points
// line buffers are block rams with registered read, no clearing pass after reset
// reset (rst_n, synchronous): level 10, raster position at fine point (0,0)
// a write to cfg_wr_en also restarts the raster at fine point (0,0)
`default_nettype none
module full_weighting_restriction_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [fwr_pkg::LEVEL_W-1:0]     cfg_wr_data,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [fwr_pkg::IN_TDATA_W-1:0]  in_tdata,   // sample
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [fwr_pkg::OUT_TDATA_W-1:0] out_tdata,  // coarse_row, coarse_col, value
  output      logic                            out_tlast
);
  import fwr_pkg::*;

  fwr_ctrl_t ctrl;
  logic      accept;

  logic      s1_valid_r, s1_valid_nxt;
  fwr_ctrl_t s1_ctrl_r;
  sample_t   s1_sample_r;
  logic      s1_fire;
  logic      out_free;

  logic [SAMPLE_W-1:0] older_q;
  logic [SAMPLE_W-1:0] newer_q;
  sample_t             value;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_FIELD_W-1:0] out_data_r;
  logic                   out_last_r;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_ctrl_r.hit || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign accept    = in_tvalid && in_tready;

  fwr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (accept),
    .ctrl        (ctrl)
  );

  fwr_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_older (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_ctrl_r.addr),
    .wdata (newer_q),
    .re    (accept),
    .raddr (ctrl.addr),
    .rdata (older_q)
  );

  fwr_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_newer (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_ctrl_r.addr),
    .wdata (s1_sample_r),
    .re    (accept),
    .raddr (ctrl.addr),
    .rdata (newer_q)
  );

  fwr_stencil u_stencil (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_fire),
    .top      (sample_t'(older_q)),
    .mid      (sample_t'(newer_q)),
    .bot      (s1_sample_r),
    .value    (value)
  );

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl_r   <= ctrl;
      s1_sample_r <= sample_t'(in_tdata[SAMPLE_W-1:0]);
    end
  end

  always_comb begin
    if (out_free) begin
      out_valid_nxt = s1_fire && s1_ctrl_r.hit;
    end else begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctrl_r.hit) begin
      out_data_r <= {value, s1_ctrl_r.coarse_col, s1_ctrl_r.coarse_row};
      out_last_r <= s1_ctrl_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: hdl/fwr_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none
module fwr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fwr_ctrl.sv
// level register, fine raster counters and coarse point detection
`default_nettype none
module fwr_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [fwr_pkg::LEVEL_W-1:0] cfg_wr_data,
  input  wire logic                   advance,
  output      fwr_pkg::fwr_ctrl_t     ctrl
);
  import fwr_pkg::*;

  logic [LEVEL_W-1:0] level_r;
  logic [CNT_W-1:0]   row_r, row_nxt;
  logic [CNT_W-1:0]   col_r, col_nxt;
  logic [LEVEL_W-1:0] lev;
  logic [CNT_W-1:0]   side_m1;
  logic [CNT_W-1:0]   side_m2;
  logic               in_range;

  always_comb begin
    if (level_r < LEVEL_W'(MIN_LEVEL)) begin
      lev = LEVEL_W'(MIN_LEVEL);
    end else if (level_r > LEVEL_W'(MAX_LEVEL)) begin
      lev = LEVEL_W'(MAX_LEVEL);
    end else begin
      lev = level_r;
    end
    side_m1 = CNT_W'(1) << lev;
    side_m2 = side_m1 - CNT_W'(1);
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (advance) begin
      if (col_r == side_m1) begin
        col_nxt = '0;
        row_nxt = (row_r == side_m1) ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LEVEL_RESET;
      row_r   <= '0;
      col_r   <= '0;
    end else if (cfg_wr_en) begin
      level_r <= cfg_wr_data;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign in_range = row_r[0] && col_r[0] &&
                    (row_r >= CNT_W'(3)) && (col_r >= CNT_W'(3)) &&
                    (row_r <= side_m2) && (col_r <= side_m2);

  always_comb begin
    ctrl.hit        = in_range;
    ctrl.last       = (row_r == side_m2) && (col_r == side_m2);
    ctrl.coarse_row = row_r[COORD_W:1];
    ctrl.coarse_col = col_r[COORD_W:1];
    ctrl.addr       = col_r[ADDR_W-1:0];
  end

endmodule
`default_nettype wire

FILE: hdl/fwr_stencil.sv
// 3x3 window registers and the 9-point full-weighting sum
`default_nettype none
module fwr_stencil (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift_en,
  input  wire fwr_pkg::sample_t top,
  input  wire fwr_pkg::sample_t mid,
  input  wire fwr_pkg::sample_t bot,
  output      fwr_pkg::sample_t value
);
  import fwr_pkg::*;

  sample_t win_r [6];
  logic signed [SUM_W-1:0] corners;
  logic signed [SUM_W-1:0] edges;
  logic signed [SUM_W-1:0] centre;
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] scaled;

  // window: [0..1] top row, [2..3] middle row, [4..5] bottom row, oldest first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= '0;
      end
    end else if (shift_en) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top;
      win_r[2] <= win_r[3];
      win_r[3] <= mid;
      win_r[4] <= win_r[5];
      win_r[5] <= bot;
    end
  end

  always_comb begin
    corners = SUM_W'(win_r[0]) + SUM_W'(top) + SUM_W'(win_r[4]) + SUM_W'(bot);
    edges   = SUM_W'(win_r[1]) + SUM_W'(win_r[2]) + SUM_W'(mid) + SUM_W'(win_r[5]);
    centre  = SUM_W'(win_r[3]);
    total   = corners + (edges <<< 1) + (centre <<< 2);
    scaled  = total >>> 4;
    value   = scaled[SAMPLE_W-1:0];
  end

endmodule
`default_nettype wire
